>>> rtl/rsr_pkg.sv
package rsr_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned RUN_W   = 16;
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } item_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_SEL  = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_UPD  = 5'b10000
  } back_state_e;

endpackage

>>> rtl/rsr_if.sv
interface rsr_in_if;
  logic                     valid;
  logic                     ready;
  logic [rsr_pkg::KEY_W-1:0] key;
  logic                     last;

  modport source (output valid, output key, output last, input ready);
  modport sink   (input valid, input key, input last, output ready);
endinterface

interface rsr_out_if;
  logic                     valid;
  logic                     ready;
  logic [rsr_pkg::KEY_W-1:0] out_key;
  logic [rsr_pkg::RUN_W-1:0] run_index;
  logic                     run_start;
  logic                     final_res;

  modport source (output valid, output out_key, output run_index, output run_start,
                  output final_res, input ready);
  modport sink   (input valid, input out_key, input run_index, input run_start,
                  input final_res, output ready);
endinterface

>>> rtl/rsr_front.sv
module rsr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rsr_in_if.sink               in_i,
  output rsr_pkg::queue_head_t head_o,
  input  logic                 pop_i
);

  rsr_pkg::item_t slot_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;
  logic           push;
  logic           pop;

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{key: in_i.key, last: in_i.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/rsr_back.sv
module rsr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsr_pkg::queue_head_t head_i,
  output logic                 pop_o,
  rsr_out_if.source            out_o
);

  localparam int unsigned E = rsr_pkg::ENTRIES;

  rsr_pkg::back_state_e state_q;

  logic [rsr_pkg::KEY_W-1:0] key_mem [E];
  logic [rsr_pkg::KEY_W-1:0] rd_data_q;

  logic [E-1:0]               valid_q;
  logic [E-1:0]               frozen_q;
  logic [rsr_pkg::CNT_W-1:0]  fill_q;
  logic [rsr_pkg::RUN_W-1:0]  run_q;
  logic                       run_has_out_q;
  logic                       drain_q;

  logic [rsr_pkg::KEY_W-1:0]  cur_key_q;
  logic                       cur_last_q;

  logic [rsr_pkg::CNT_W-1:0]  scan_cnt_q;
  logic                       rd_vld_q;
  logic [rsr_pkg::IDX_W-1:0]  rd_idx_q;
  logic [rsr_pkg::IDX_W-1:0]  rd_addr;

  logic                       ba_found_q;
  logic [rsr_pkg::IDX_W-1:0]  ba_idx_q;
  logic [rsr_pkg::KEY_W-1:0]  ba_key_q;
  logic                       bu_found_q;
  logic [rsr_pkg::IDX_W-1:0]  bu_idx_q;
  logic [rsr_pkg::KEY_W-1:0]  bu_key_q;

  logic [rsr_pkg::IDX_W-1:0]  sel_idx_q;
  logic [rsr_pkg::KEY_W-1:0]  sel_key_q;

  logic                       out_vld_q;
  logic [rsr_pkg::KEY_W-1:0]  out_key_q;
  logic [rsr_pkg::RUN_W-1:0]  out_run_q;
  logic                       out_start_q;
  logic                       out_final_q;
  logic                       out_free;

  logic                       mem_we;
  logic [rsr_pkg::IDX_W-1:0]  mem_wa;
  logic [rsr_pkg::KEY_W-1:0]  mem_wd;
  logic                       fill_phase;
  logic                       scan_rd;

  assign out_o.valid     = out_vld_q;
  assign out_o.out_key   = out_key_q;
  assign out_o.run_index = out_run_q;
  assign out_o.run_start = out_start_q;
  assign out_o.final_res = out_final_q;

  assign out_free   = !out_vld_q || out_o.ready;
  assign pop_o      = (state_q == rsr_pkg::ST_IDLE) && head_i.valid;
  assign fill_phase = (fill_q < rsr_pkg::CNT_W'(E));
  assign scan_rd    = (state_q == rsr_pkg::ST_SCAN) && (scan_cnt_q != rsr_pkg::CNT_W'(E));
  assign rd_addr    = scan_rd ? scan_cnt_q[rsr_pkg::IDX_W-1:0] : '0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_q[rsr_pkg::IDX_W-1:0];
    mem_wd = head_i.item.key;
    if (pop_o && fill_phase) begin
      mem_we = 1'b1;
    end else if ((state_q == rsr_pkg::ST_EMIT) && out_free && !drain_q) begin
      mem_we = 1'b1;
      mem_wa = sel_idx_q;
      mem_wd = cur_key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= key_mem[rd_addr];
  end

  // Running minimum over the scan: one over all valid entries, one over the unfrozen ones.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ba_found_q <= 1'b0;
      ba_idx_q   <= '0;
      ba_key_q   <= '0;
      bu_found_q <= 1'b0;
      bu_idx_q   <= '0;
      bu_key_q   <= '0;
    end else if (state_q != rsr_pkg::ST_SCAN) begin
      ba_found_q <= 1'b0;
      bu_found_q <= 1'b0;
    end else if (rd_vld_q && valid_q[rd_idx_q]) begin
      if (!ba_found_q || (rd_data_q < ba_key_q)) begin
        ba_found_q <= 1'b1;
        ba_idx_q   <= rd_idx_q;
        ba_key_q   <= rd_data_q;
      end
      if (!frozen_q[rd_idx_q] && (!bu_found_q || (rd_data_q < bu_key_q))) begin
        bu_found_q <= 1'b1;
        bu_idx_q   <= rd_idx_q;
        bu_key_q   <= rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rsr_pkg::ST_IDLE;
      valid_q       <= '0;
      frozen_q      <= '0;
      fill_q        <= '0;
      run_q         <= '0;
      run_has_out_q <= 1'b0;
      drain_q       <= 1'b0;
      cur_key_q     <= '0;
      cur_last_q    <= 1'b0;
      scan_cnt_q    <= '0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
      sel_idx_q     <= '0;
      sel_key_q     <= '0;
      out_vld_q     <= 1'b0;
      out_key_q     <= '0;
      out_run_q     <= '0;
      out_start_q   <= 1'b0;
      out_final_q   <= 1'b0;
    end else begin
      if (out_o.ready && !((state_q == rsr_pkg::ST_EMIT) && out_free)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        rsr_pkg::ST_IDLE: begin
          if (head_i.valid) begin
            cur_key_q  <= head_i.item.key;
            cur_last_q <= head_i.item.last;
            scan_cnt_q <= '0;
            rd_vld_q   <= 1'b0;
            if (fill_phase) begin
              valid_q[fill_q[rsr_pkg::IDX_W-1:0]]  <= 1'b1;
              frozen_q[fill_q[rsr_pkg::IDX_W-1:0]] <= 1'b0;
              fill_q <= fill_q + rsr_pkg::CNT_W'(1);
              if (head_i.item.last) begin
                drain_q <= 1'b1;
                state_q <= rsr_pkg::ST_SCAN;
              end
            end else begin
              state_q <= rsr_pkg::ST_SCAN;
            end
          end
        end
        rsr_pkg::ST_SCAN: begin
          if (scan_rd) begin
            rd_vld_q   <= 1'b1;
            rd_idx_q   <= scan_cnt_q[rsr_pkg::IDX_W-1:0];
            scan_cnt_q <= scan_cnt_q + rsr_pkg::CNT_W'(1);
          end else begin
            rd_vld_q <= 1'b0;
            state_q  <= rsr_pkg::ST_SEL;
          end
        end
        rsr_pkg::ST_SEL: begin
          if (!ba_found_q) begin
            // The store is empty, which only ends a drain: the stream starts afresh.
            valid_q       <= '0;
            frozen_q      <= '0;
            fill_q        <= '0;
            run_q         <= '0;
            run_has_out_q <= 1'b0;
            drain_q       <= 1'b0;
            state_q       <= rsr_pkg::ST_IDLE;
          end else begin
            sel_idx_q <= bu_found_q ? bu_idx_q : ba_idx_q;
            sel_key_q <= bu_found_q ? bu_key_q : ba_key_q;
            if (!bu_found_q) begin
              run_q         <= (run_q == rsr_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
              frozen_q      <= '0;
              run_has_out_q <= 1'b0;
            end
            state_q <= rsr_pkg::ST_EMIT;
          end
        end
        rsr_pkg::ST_EMIT: begin
          if (out_free) begin
            out_vld_q     <= 1'b1;
            out_key_q     <= sel_key_q;
            out_run_q     <= run_q;
            out_start_q   <= !run_has_out_q;
            out_final_q   <= drain_q ? ($countones(valid_q) == 1) : !cur_last_q;
            run_has_out_q <= 1'b1;
            if (drain_q) begin
              valid_q[sel_idx_q]  <= 1'b0;
              frozen_q[sel_idx_q] <= 1'b0;
              scan_cnt_q          <= '0;
              state_q             <= rsr_pkg::ST_SCAN;
            end else begin
              valid_q[sel_idx_q]  <= 1'b1;
              frozen_q[sel_idx_q] <= (cur_key_q < sel_key_q);
              state_q             <= rsr_pkg::ST_UPD;
            end
          end
        end
        rsr_pkg::ST_UPD: begin
          if ((valid_q & ~frozen_q) == '0) begin
            run_q         <= (run_q == rsr_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
            frozen_q      <= '0;
            run_has_out_q <= 1'b0;
          end
          scan_cnt_q <= '0;
          if (cur_last_q) begin
            drain_q <= 1'b1;
            state_q <= rsr_pkg::ST_SCAN;
          end else begin
            state_q <= rsr_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= rsr_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/replacement_selection_runs.sv
// Replacement selection run generator.
// Keys enter on in_i (key, last) and sorted keys leave on out_o with their run
// number, a run_start flag on the first word of every run and final_res on the
// last word caused by an input word. Both channels use valid/ready.
// A two-word queue sits between the input side and the selection engine, so
// the input keeps taking words while the engine works or the output stalls.
// While the store is filling, a word that is not marked last is written into
// it and gives no output. Once it is full, for each word the engine scans the
// key memory one entry a cycle through its single read port, selects, emits
// and then rechecks the frozen marks.
// A word marked last then drains the store one result at a time, after which
// the valid and frozen marks, the fill count and the run counter return to
// their reset values and a new stream begins at run 0.
// A stalled receiver holds the result in the output register; the engine
// waits for it, and the queue fills and then lowers in_i.ready.
// Reset clears the queue, the valid and frozen marks, the fill count and the
// run counter; no clearing pass is needed.
module replacement_selection_runs (
  input logic clk_i,
  input logic rst_ni,
  rsr_in_if.sink    in_i,
  rsr_out_if.source out_o
);

  rsr_pkg::queue_head_t head;
  logic                 pop;

  rsr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  rsr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

>>> rtl/rsr_checker.sv
module rsr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rsr_pkg::KEY_W-1:0] out_key_i,
  input logic [rsr_pkg::RUN_W-1:0] run_index_i,
  input logic                      run_start_i,
  input logic                      final_res_i
);

  logic                      have_prev_q;
  logic [rsr_pkg::KEY_W-1:0] prev_key_q;
  logic [rsr_pkg::RUN_W-1:0] prev_run_q;
  logic                      word_taken;

  assign word_taken = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_key_q  <= '0;
      prev_run_q  <= '0;
    end else if (word_taken) begin
      have_prev_q <= 1'b1;
      prev_key_q  <= out_key_i;
      prev_run_q  <= run_index_i;
    end
  end

  // A stalled word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_key_i)
      && $stable(run_index_i) && $stable(run_start_i) && $stable(final_res_i))
    else $error("output word changed while stalled");

  // Within a run the keys ascend and the run number stays.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_taken && !run_start_i && have_prev_q |->
      (run_index_i == prev_run_q) && (out_key_i >= prev_key_q))
    else $error("run order broken");

  // The first word after reset opens run 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_taken && !have_prev_q |-> run_start_i && (run_index_i == '0))
    else $error("first word does not open run 0");

  // Reset clears the output valid.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind replacement_selection_runs rsr_checker u_rsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_key_i   (out_o.out_key),
  .run_index_i (out_o.run_index),
  .run_start_i (out_o.run_start),
  .final_res_i (out_o.final_res)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_ERR_SHOWN = 10;

  typedef struct {
    logic [rsr_pkg::KEY_W-1:0] out_key;
    logic [rsr_pkg::RUN_W-1:0] run_index;
    logic                      run_start;
    logic                      final_res;
  } sorted_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rsr_in_if  in_ch ();
  rsr_out_if out_ch ();

  replacement_selection_runs dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [rsr_pkg::KEY_W-1:0] st_keys [rsr_pkg::ENTRIES];
  logic                      st_valid [rsr_pkg::ENTRIES];
  logic                      st_frozen [rsr_pkg::ENTRIES];
  int unsigned               st_fill;
  logic [rsr_pkg::KEY_W-1:0] st_last_out;
  logic [rsr_pkg::RUN_W-1:0] st_run;
  logic                      st_run_begun;

  rsr_pkg::item_t pending_keys [$];
  sorted_word_t   expected_words [$];
  int unsigned    mismatches = 0;
  bit             calm = 1'b0;
  bit             hold_send = 1'b0;
  bit             in_taken = 1'b0;

  function automatic void clear_store();
    for (int i = 0; i < rsr_pkg::ENTRIES; i++) begin
      st_keys[i] = '0;
      st_valid[i] = 1'b0;
      st_frozen[i] = 1'b0;
    end
    st_fill = 0;
    st_last_out = '0;
    st_run = '0;
    st_run_begun = 1'b0;
  endfunction

  function automatic void thaw_into_next_run();
    if (st_run != rsr_pkg::RUN_MAX) st_run++;
    for (int i = 0; i < rsr_pkg::ENTRIES; i++) st_frozen[i] = 1'b0;
    st_run_begun = 1'b0;
  endfunction

  function automatic int smallest_live();
    int best;
    best = -1;
    for (int i = 0; i < rsr_pkg::ENTRIES; i++)
      if (st_valid[i] && !st_frozen[i])
        if (best < 0 || st_keys[i] < st_keys[best]) best = i;
    return best;
  endfunction

  function automatic int choose_entry();
    int idx;
    bit any;
    idx = smallest_live();
    any = 1'b0;
    for (int i = 0; i < rsr_pkg::ENTRIES; i++) any |= st_valid[i];
    if (idx < 0 && any) begin
      thaw_into_next_run();
      idx = smallest_live();
    end
    return idx;
  endfunction

  function automatic void emit_entry(int idx, ref sorted_word_t outs[$]);
    sorted_word_t w;
    w.out_key = st_keys[idx];
    w.run_index = st_run;
    w.run_start = !st_run_begun;
    w.final_res = 1'b0;
    st_last_out = st_keys[idx];
    st_run_begun = 1'b1;
    outs.push_back(w);
  endfunction

  function automatic void predict_sorted(rsr_pkg::item_t it);
    sorted_word_t outs[$];
    int idx;
    bit all_frozen;
    if (st_fill < rsr_pkg::ENTRIES) begin
      st_keys[st_fill] = it.key;
      st_valid[st_fill] = 1'b1;
      st_frozen[st_fill] = 1'b0;
      st_fill++;
    end else begin
      idx = choose_entry();
      if (idx >= 0) begin
        emit_entry(idx, outs);
        st_keys[idx] = it.key;
        st_valid[idx] = 1'b1;
        st_frozen[idx] = it.key < st_last_out;
        all_frozen = 1'b1;
        for (int i = 0; i < rsr_pkg::ENTRIES; i++)
          if (st_valid[i] && !st_frozen[i]) all_frozen = 1'b0;
        if (all_frozen) thaw_into_next_run();
      end
    end
    if (it.last) begin
      idx = choose_entry();
      while (idx >= 0) begin
        emit_entry(idx, outs);
        st_valid[idx] = 1'b0;
        st_frozen[idx] = 1'b0;
        idx = choose_entry();
      end
      clear_store();
    end
    if (outs.size() > 0) outs[outs.size()-1].final_res = 1'b1;
    foreach (outs[i]) expected_words.push_back(outs[i]);
  endfunction

  // Driver: idle bursts between words, none once calm is set.
  int unsigned send_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.key <= '0;
      in_ch.last <= 1'b0;
    end else begin
      // The word on the bus may move on only once the monitor has seen it taken.
      if (!in_ch.valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_keys.size() > 0 && !hold_send) begin
          in_ch.valid <= 1'b1;
          in_ch.key <= pending_keys[0].key;
          in_ch.last <= pending_keys[0].last;
          void'(pending_keys.pop_front());
          if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls.
  int unsigned stall_left = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  int unsigned words_sent = 0;
  always @(posedge clk_i) begin
    rsr_pkg::item_t it;
    sorted_word_t want;
    in_taken = rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        it.key = in_ch.key;
        it.last = in_ch.last;
        predict_sorted(it);
        words_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_ERR_SHOWN)
            $display("unexpected word key=%h run=%0d", out_ch.out_key, out_ch.run_index);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.out_key !== want.out_key || out_ch.run_index !== want.run_index ||
              out_ch.run_start !== want.run_start ||
              out_ch.final_res !== want.final_res) begin
            mismatches++;
            if (mismatches <= MAX_ERR_SHOWN)
              $display({"mismatch: expected key=%h run=%0d start=%b final=%b, ",
                        "got key=%h run=%0d start=%b final=%b"},
                       want.out_key, want.run_index, want.run_start, want.final_res,
                       out_ch.out_key, out_ch.run_index, out_ch.run_start,
                       out_ch.final_res);
          end
        end
      end
    end
  end

  function automatic void queue_key(logic [rsr_pkg::KEY_W-1:0] k, logic l);
    rsr_pkg::item_t it;
    it.key = k;
    it.last = l;
    pending_keys.push_back(it);
  endfunction

  function automatic logic [rsr_pkg::KEY_W-1:0] random_key();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 20);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 20);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned total;
    int unsigned len;
    clear_store();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: last key while filling, then a short stream.
    queue_key(32'd7, 1'b0);
    queue_key(32'hFFFF_FFFF, 1'b0);
    queue_key(32'd0, 1'b1);
    queue_key(32'd5, 1'b1);
    // A full store with equal keys, a smaller key that freezes, extremes.
    for (int i = 0; i < rsr_pkg::ENTRIES; i++) queue_key(32'd100 + (i % 3), 1'b0);
    queue_key(32'd100, 1'b0);
    queue_key(32'd0, 1'b0);
    queue_key(32'hFFFF_FFFF, 1'b1);

    // Pause until every expected word is back.
    while (pending_keys.size() > 0 || in_ch.valid) @(posedge clk_i);
    hold_send = 1'b1;
    while (expected_words.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;

    // Random streams; keys from a descending series, mixed in at random, force frequent run changes.
    total = 0;
    while (total < 107) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(17, 40);
      if (len > 107 - total) len = 107 - total;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) queue_key(32'hFFFF_0000 - i * 7, i == len - 1);
        else queue_key(random_key(), i == len - 1);
      end
      total += len;
    end

    // The last part of the run goes without idling.
    while (pending_keys.size() > 30) @(posedge clk_i);
    calm = 1'b1;

    while (pending_keys.size() > 0 || in_ch.valid) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> replacement_selection_runs.f
rtl/rsr_pkg.sv
rtl/rsr_if.sv
rtl/rsr_front.sv
rtl/rsr_back.sv
rtl/replacement_selection_runs.sv
rtl/rsr_checker.sv
bench/testbench.sv
